// ===== design/aes_pkg.sv =====
package aes_pkg;

  localparam int NumRounds = 10;

  typedef logic [127:0] block_t;

  typedef enum logic [0:0] {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } reg_index_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [NumRounds] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  // Byte i of a block sits in bits 127-8i downto 120-8i.
  function automatic logic [7:0] get_byte(block_t b, int i);
    return b[127 - 8 * i -: 8];
  endfunction

  function automatic logic [7:0] xtime(logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic block_t next_key(block_t rk, logic [7:0] rc);
    logic [7:0] k [16];
    for (int i = 0; i < 16; i++) k[i] = get_byte(rk, i);
    k[0] = k[0] ^ SBOX[k[13]] ^ rc;
    k[1] = k[1] ^ SBOX[k[14]];
    k[2] = k[2] ^ SBOX[k[15]];
    k[3] = k[3] ^ SBOX[k[12]];
    for (int i = 4; i < 16; i++) k[i] = k[i] ^ k[i - 4];
    for (int i = 0; i < 16; i++) rk[127 - 8 * i -: 8] = k[i];
    return rk;
  endfunction

  function automatic block_t round_fn(block_t s, block_t rk, logic last);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, all;
    block_t o;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[r + 4 * c] = SBOX[get_byte(s, r + 4 * ((c + r) % 4))];
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
        all = a0 ^ a1 ^ a2 ^ a3;
        t[4 * c]     = a0 ^ all ^ xtime(a0 ^ a1);
        t[4 * c + 1] = a1 ^ all ^ xtime(a1 ^ a2);
        t[4 * c + 2] = a2 ^ all ^ xtime(a2 ^ a3);
        t[4 * c + 3] = a3 ^ all ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) o[127 - 8 * i -: 8] = t[i];
    return o ^ rk;
  endfunction

endpackage

// ===== design/aes_round.sv =====
module aes_round (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic [7:0]           rcon,
  input  logic                 last,
  input  logic                 valid_in,
  input  aes_pkg::block_t      state_in,
  input  aes_pkg::block_t      key_in,
  output logic                 valid_out,
  output aes_pkg::block_t      state_out,
  output aes_pkg::block_t      key_out
);

  aes_pkg::block_t key_next;

  assign key_next = aes_pkg::next_key(key_in, rcon);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (advance) begin
      valid_out <= valid_in;
    end
    if (advance) begin
      key_out   <= key_next;
      state_out <= aes_pkg::round_fn(state_in, key_next, last);
    end
  end

endmodule

// ===== design/aes128_block_encrypt.sv =====
// An accepted input block is registered into the AddRoundKey stage, then moves through one stage
// per round, each with its own key expansion step.
// Throughput: one block per cycle; the pipeline stalls as a whole when the
// result is not taken. Each block carries its own round keys, so key writes
// affect only later blocks. Synchronous reset clears all valid bits and the key.
module aes128_block_encrypt (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] plain_high,
  input  logic [63:0] plain_low,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] cipher_high,
  output logic [63:0] cipher_low,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int N = aes_pkg::NumRounds;

  logic            key_hi_unused;
  aes_pkg::block_t key;
  logic            advance;
  logic            v [N + 1];
  aes_pkg::block_t st [N + 1];
  aes_pkg::block_t rk [N + 1];

  assign key_hi_unused = 1'b0;
  assign advance  = !v[N] || out_ready;
  assign in_ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      key  <= '0;
      v[0] <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (aes_pkg::reg_index_t'(cfg_index))
          aes_pkg::REG_KEY_HIGH: key[127:64] <= cfg_data;
          aes_pkg::REG_KEY_LOW:  key[63:0]   <= cfg_data;
          default: ;
        endcase
      end
      if (advance) v[0] <= in_valid;
    end
    if (advance) begin
      st[0] <= {plain_high, plain_low} ^ key;
      rk[0] <= key;
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_round
    aes_round u_round (
      .clk(clk), .rst(rst), .advance(advance),
      .rcon(aes_pkg::RCON[g]), .last((g == N - 1) ^ key_hi_unused),
      .valid_in(v[g]), .state_in(st[g]), .key_in(rk[g]),
      .valid_out(v[g + 1]), .state_out(st[g + 1]), .key_out(rk[g + 1])
    );
  end

  assign out_valid   = v[N];
  assign cipher_high = st[N][127:64];
  assign cipher_low  = st[N][63:0];

endmodule

// ===== design/aes_checker.sv =====
module aes_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] cipher_high,
  input logic [63:0] cipher_low
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cipher_high) && $stable(cipher_low))
    else $error("result changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken during output stall");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind aes128_block_encrypt aes_checker u_aes_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .cipher_high(cipher_high), .cipher_low(cipher_low)
);
